### src/sdi_pkg.sv
// Shared types, constants and saturating helpers for the spring-damper integrator.
package sdi_pkg;

   localparam int unsigned FracBits = 16;   // Q(32-F).F for positions, forces, coefficients
   localparam int unsigned DtFrac   = 16;   // time_step is Q0.16
   localparam int unsigned MulW     = 33;   // multiplier operand width
   localparam int unsigned ProdW    = 2 * MulW;

   typedef enum logic {
      OP_START = 1'b0,
      OP_TICK  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      CSR_STIFFNESS    = 3'd0,
      CSR_DAMPING      = 3'd1,
      CSR_INVERSE_MASS = 3'd2,
      CSR_SETTLE_PREC  = 3'd3,
      CSR_MAX_DURATION = 3'd4,
      CSR_TIME_STEP    = 3'd5
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL_KS,
      ST_MUL_DV,
      ST_FORCE,
      ST_MUL_IM,
      ST_ACCEL,
      ST_MUL_TA,
      ST_VEL,
      ST_MUL_TV,
      ST_POS,
      ST_SDIFF,
      ST_SQ_D,
      ST_SQ_V,
      ST_SQ_ACC,
      ST_SQ_P,
      ST_CMP,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic [31:0] stiffness;
      logic [31:0] damping;
      logic [31:0] inverse_mass;
      logic [31:0] settle_precision;
      logic [15:0] max_duration_ms;
      logic [15:0] time_step;
   } cfg_type;

   typedef struct packed {
      logic signed [MulW-1:0] a;
      logic signed [MulW-1:0] b;
   } mul_req_type;

   // clamp to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [ProdW-1:0] v);
      if (v > $signed({{(ProdW-31){1'b0}}, {31{1'b1}}}))
         return 32'sh7FFF_FFFF;
      else if (v < $signed({{(ProdW-31){1'b1}}, {31{1'b0}}}))
         return 32'sh8000_0000;
      else
         return v[31:0];
   endfunction

   // floor shift of a full product, then clamp
   function automatic logic signed [31:0] sat_shift(input logic signed [ProdW-1:0] p,
                                                   input int unsigned sh);
      logic signed [ProdW-1:0] s;
      s = p >>> sh;
      return sat32(s);
   endfunction

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] x,
                                                 input logic signed [31:0] y);
      logic signed [32:0] s;
      s = {x[31], x} + {y[31], y};
      return sat32(ProdW'(s));
   endfunction

   function automatic logic signed [31:0] sat_sub(input logic signed [31:0] x,
                                                 input logic signed [31:0] y);
      logic signed [32:0] s;
      s = {x[31], x} - {y[31], y};
      return sat32(ProdW'(s));
   endfunction

   function automatic logic signed [MulW-1:0] mag(input logic signed [31:0] v);
      logic signed [MulW-1:0] e;
      e = {v[31], v};
      return v[31] ? -e : e;
   endfunction

endpackage

### src/sdi_if.sv
// Valid/ready channel interfaces: request, response and register write.
interface sdi_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic signed [31:0] start_x;
   logic signed [31:0] start_y;
   logic signed [31:0] goal_x;
   logic signed [31:0] goal_y;
   logic        [15:0] elapsed_ms;

   modport source (output valid, op, start_x, start_y, goal_x, goal_y, elapsed_ms,
                   input ready);
   modport sink   (input valid, op, start_x, start_y, goal_x, goal_y, elapsed_ms,
                   output ready);
endinterface

interface sdi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic               moving;
   logic               finished;

   modport source (output valid, out_x, out_y, moving, finished, input ready);
   modport sink   (input valid, out_x, out_y, moving, finished, output ready);
endinterface

interface sdi_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### src/sdi_csr.sv
// Configuration register file.
module sdi_csr (
   input  logic            clock,
   input  logic            reset,
   sdi_csr_if.sink         csr,
   output sdi_pkg::cfg_type cfg
);

   sdi_pkg::cfg_type cfg_ff, cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (sdi_pkg::csr_index_type'(csr.index))
            sdi_pkg::CSR_STIFFNESS:    cfg_in.stiffness        = csr.data;
            sdi_pkg::CSR_DAMPING:      cfg_in.damping          = csr.data;
            sdi_pkg::CSR_INVERSE_MASS: cfg_in.inverse_mass     = csr.data;
            sdi_pkg::CSR_SETTLE_PREC:  cfg_in.settle_precision = csr.data;
            sdi_pkg::CSR_MAX_DURATION: cfg_in.max_duration_ms  = csr.data[15:0];
            sdi_pkg::CSR_TIME_STEP:    cfg_in.time_step        = csr.data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stiffness        <= 32'd6553600;
         cfg_ff.damping          <= 32'd655360;
         cfg_ff.inverse_mass     <= 32'd65536;
         cfg_ff.settle_precision <= 32'd655;
         cfg_ff.max_duration_ms  <= 16'd1000;
         cfg_ff.time_step        <= 16'd1049;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### src/sdi_mul.sv
// Shared signed multiplier with registered product.
module sdi_mul (
   input  logic                                clock,
   input  sdi_pkg::mul_req_type                mul_req,
   output logic signed [sdi_pkg::ProdW-1:0]    prod_ff
);

   logic signed [sdi_pkg::ProdW-1:0] prod_in;

   assign prod_in = mul_req.a * mul_req.b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

### src/sdi_seq.sv
// Sequencer and state datapath: drives the shared multiplier, holds motion state.
module sdi_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  sdi_pkg::cfg_type                 cfg,
   sdi_req_if.sink                          req,
   sdi_rsp_if.source                        rsp,
   output sdi_pkg::mul_req_type             mul_req,
   input  logic signed [sdi_pkg::ProdW-1:0] mul_p
);

   sdi_pkg::seq_state_type state_ff, state_in;
   logic               axis_ff, axis_in;
   logic               running_ff, running_in;
   logic               fin_ff, fin_in;
   logic signed [31:0] d_ff, d_in;
   logic signed [31:0] fs_ff, fs_in;
   logic        [63:0] dsq_ff, dsq_in;
   logic        [63:0] vsq_ff, vsq_in;
   logic signed [31:0] pos_ff [2];
   logic signed [31:0] pos_in [2];
   logic signed [31:0] vel_ff [2];
   logic signed [31:0] vel_in [2];
   logic signed [31:0] tgt_ff [2];
   logic signed [31:0] tgt_in [2];
   logic               out_valid_ff, out_valid_in;
   logic signed [31:0] out_x_ff, out_x_in;
   logic signed [31:0] out_y_ff, out_y_in;
   logic               out_moving_ff, out_moving_in;
   logic               out_fin_ff, out_fin_in;

   logic               take;
   logic               out_free;
   logic               timeout;
   logic signed [31:0] pos_cur, vel_cur, tgt_cur;

   assign req.ready    = (state_ff == sdi_pkg::ST_IDLE);
   assign take         = req.valid && req.ready;
   assign out_free     = !out_valid_ff || rsp.ready;
   assign timeout      = req.elapsed_ms > cfg.max_duration_ms;
   assign pos_cur      = pos_ff[axis_ff];
   assign vel_cur      = vel_ff[axis_ff];
   assign tgt_cur      = tgt_ff[axis_ff];

   assign rsp.valid    = out_valid_ff;
   assign rsp.out_x    = out_x_ff;
   assign rsp.out_y    = out_y_ff;
   assign rsp.moving   = out_moving_ff;
   assign rsp.finished = out_fin_ff;

   always_comb begin
      state_in      = state_ff;
      axis_in       = axis_ff;
      running_in    = running_ff;
      fin_in        = fin_ff;
      d_in          = d_ff;
      fs_in         = fs_ff;
      dsq_in        = dsq_ff;
      vsq_in        = vsq_ff;
      pos_in        = pos_ff;
      vel_in        = vel_ff;
      tgt_in        = tgt_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_moving_in = out_moving_ff;
      out_fin_in    = out_fin_ff;
      mul_req.a     = '0;
      mul_req.b     = '0;

      unique case (state_ff)
         sdi_pkg::ST_IDLE: begin
            if (take) begin
               fin_in = 1'b0;
               if (req.op == sdi_pkg::OP_START) begin
                  pos_in[0]  = req.start_x;
                  pos_in[1]  = req.start_y;
                  tgt_in[0]  = req.goal_x;
                  tgt_in[1]  = req.goal_y;
                  vel_in[0]  = '0;
                  vel_in[1]  = '0;
                  running_in = 1'b1;
                  state_in   = sdi_pkg::ST_DONE;
               end else if (!running_ff) begin
                  state_in = sdi_pkg::ST_DONE;
               end else if (timeout) begin
                  running_in = 1'b0;
                  fin_in     = 1'b1;
                  state_in   = sdi_pkg::ST_DONE;
               end else begin
                  axis_in  = 1'b0;
                  dsq_in   = '0;
                  vsq_in   = '0;
                  state_in = sdi_pkg::ST_DIFF;
               end
            end
         end
         sdi_pkg::ST_DIFF: begin
            d_in     = sdi_pkg::sat_sub(tgt_cur, pos_cur);
            state_in = sdi_pkg::ST_MUL_KS;
         end
         sdi_pkg::ST_MUL_KS: begin
            mul_req.a = {1'b0, cfg.stiffness};
            mul_req.b = {d_ff[31], d_ff};
            state_in  = sdi_pkg::ST_MUL_DV;
         end
         sdi_pkg::ST_MUL_DV: begin
            fs_in     = sdi_pkg::sat_shift(mul_p, sdi_pkg::FracBits);
            mul_req.a = {1'b0, cfg.damping};
            mul_req.b = {vel_cur[31], vel_cur};
            state_in  = sdi_pkg::ST_FORCE;
         end
         sdi_pkg::ST_FORCE: begin
            d_in     = sdi_pkg::sat_sub(fs_ff, sdi_pkg::sat_shift(mul_p, sdi_pkg::FracBits));
            state_in = sdi_pkg::ST_MUL_IM;
         end
         sdi_pkg::ST_MUL_IM: begin
            mul_req.a = {1'b0, cfg.inverse_mass};
            mul_req.b = {d_ff[31], d_ff};
            state_in  = sdi_pkg::ST_ACCEL;
         end
         sdi_pkg::ST_ACCEL: begin
            d_in     = sdi_pkg::sat_shift(mul_p, sdi_pkg::FracBits);
            state_in = sdi_pkg::ST_MUL_TA;
         end
         sdi_pkg::ST_MUL_TA: begin
            mul_req.a = {17'd0, cfg.time_step};
            mul_req.b = {d_ff[31], d_ff};
            state_in  = sdi_pkg::ST_VEL;
         end
         sdi_pkg::ST_VEL: begin
            vel_in[axis_ff] = sdi_pkg::sat_add(vel_cur,
                                               sdi_pkg::sat_shift(mul_p, sdi_pkg::DtFrac));
            state_in = sdi_pkg::ST_MUL_TV;
         end
         sdi_pkg::ST_MUL_TV: begin
            mul_req.a = {17'd0, cfg.time_step};
            mul_req.b = {vel_cur[31], vel_cur};
            state_in  = sdi_pkg::ST_POS;
         end
         sdi_pkg::ST_POS: begin
            pos_in[axis_ff] = sdi_pkg::sat_add(pos_cur,
                                               sdi_pkg::sat_shift(mul_p, sdi_pkg::DtFrac));
            axis_in  = !axis_ff;
            state_in = axis_ff ? sdi_pkg::ST_SDIFF : sdi_pkg::ST_DIFF;
         end
         sdi_pkg::ST_SDIFF: begin
            d_in     = sdi_pkg::sat_sub(tgt_cur, pos_cur);
            state_in = sdi_pkg::ST_SQ_D;
         end
         sdi_pkg::ST_SQ_D: begin
            mul_req.a = sdi_pkg::mag(d_ff);
            mul_req.b = sdi_pkg::mag(d_ff);
            state_in  = sdi_pkg::ST_SQ_V;
         end
         sdi_pkg::ST_SQ_V: begin
            dsq_in    = dsq_ff + mul_p[63:0];
            mul_req.a = sdi_pkg::mag(vel_cur);
            mul_req.b = sdi_pkg::mag(vel_cur);
            state_in  = sdi_pkg::ST_SQ_ACC;
         end
         sdi_pkg::ST_SQ_ACC: begin
            vsq_in   = vsq_ff + mul_p[63:0];
            axis_in  = !axis_ff;
            state_in = axis_ff ? sdi_pkg::ST_SQ_P : sdi_pkg::ST_SDIFF;
         end
         sdi_pkg::ST_SQ_P: begin
            mul_req.a = {1'b0, cfg.settle_precision};
            mul_req.b = {1'b0, cfg.settle_precision};
            state_in  = sdi_pkg::ST_CMP;
         end
         sdi_pkg::ST_CMP: begin
            if ((dsq_ff < mul_p[63:0]) && (vsq_ff < mul_p[63:0])) begin
               running_in = 1'b0;
               fin_in     = 1'b1;
            end
            state_in = sdi_pkg::ST_DONE;
         end
         sdi_pkg::ST_DONE: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_x_in      = pos_ff[0];
               out_y_in      = pos_ff[1];
               out_moving_in = running_ff;
               out_fin_in    = fin_ff;
               state_in      = sdi_pkg::ST_IDLE;
            end
         end
         default: state_in = sdi_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdi_pkg::ST_IDLE;
         axis_ff      <= 1'b0;
         running_ff   <= 1'b0;
         fin_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff[0]    <= '0;
         pos_ff[1]    <= '0;
         vel_ff[0]    <= '0;
         vel_ff[1]    <= '0;
         tgt_ff[0]    <= '0;
         tgt_ff[1]    <= '0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         running_ff   <= running_in;
         fin_ff       <= fin_in;
         out_valid_ff <= out_valid_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         tgt_ff       <= tgt_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff          <= d_in;
      fs_ff         <= fs_in;
      dsq_ff        <= dsq_in;
      vsq_ff        <= vsq_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_moving_ff <= out_moving_in;
      out_fin_ff    <= out_fin_in;
   end

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      take && (req.op == sdi_pkg::OP_START) |=> running_ff && !fin_ff)
      else $error("start transaction did not set running");

   a_timeout_stops: assert property (@(posedge clock) disable iff (reset)
      take && (req.op == sdi_pkg::OP_TICK) && running_ff && timeout
      |=> !running_ff && fin_ff && (state_ff == sdi_pkg::ST_DONE))
      else $error("timeout did not finish motion");

   a_finished_not_moving: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_fin_ff |-> !out_moving_ff)
      else $error("result both finished and moving");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sdi_pkg::ST_DONE) && !out_free |=> (state_ff == sdi_pkg::ST_DONE))
      else $error("result dropped while output register full");

   a_axis_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sdi_pkg::ST_IDLE) |-> !axis_ff)
      else $error("axis index not back at x when idle");

endmodule

### src/spring_damper_integrator_2d.sv
// Top level of the two-axis spring-damper integrator.
// Start transaction, idle tick and timed-out tick go from accept straight to done;
//   an integrating tick runs accept, x then y update, x then y settle, then finish.
// Throughput: one transaction at a time; req ready only while the sequencer is idle.
//   The single shared 33x33 multiplier serves every multiply step of a tick.
// Reset (synchronous, active high): registers to defaults, state zero, not running.
module spring_damper_integrator_2d (
   input  logic      clock,
   input  logic      reset,
   sdi_req_if.sink   req_chan,
   sdi_rsp_if.source rsp_chan,
   sdi_csr_if.sink   csr_chan
);

   // configuration, to be written only while idle; keeping to this is up to the user
   sdi_pkg::cfg_type cfg;

   // operands from the sequencer, registered product back to it
   sdi_pkg::mul_req_type             mul_req;
   logic signed [sdi_pkg::ProdW-1:0] mul_p;

   sdi_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_chan),
      .cfg   (cfg)
   );

   // one multiplier serves force, acceleration, integration, squared-norm and squared-precision steps
   sdi_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod_ff (mul_p)
   );

   // sequencer: per axis diff, k*d, c*v, force, *1/m, dt*a, v update, dt*v, p update;
   // then squared distance and speed per axis, squared precision, compare.
   // Output register lets a result wait while the next transaction is taken.
   sdi_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req     (req_chan),
      .rsp     (rsp_chan),
      .mul_req (mul_req),
      .mul_p   (mul_p)
   );

endmodule

### tb/sv/sdi_motion_checker.sv
// Observer for the spring-damper integrator: predicts each response and compares it.
module sdi_motion_checker (
   input  logic clock,
   input  logic reset,
   sdi_req_if   req,
   sdi_rsp_if   rsp,
   sdi_csr_if   csr,
   output int   errors,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] DefStiffness   = 32'd6553600;
   localparam logic [31:0] DefDamping     = 32'd655360;
   localparam logic [31:0] DefInverseMass = 32'd65536;
   localparam logic [31:0] DefSettlePrec  = 32'd655;
   localparam logic [15:0] DefMaxDuration = 16'd1000;
   localparam logic [15:0] DefTimeStep    = 16'd1049;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic               moving;
      logic               finished;
   } motion_sample_type;

   sdi_pkg::cfg_type   params;
   logic signed [31:0] body_pos [2];
   logic signed [31:0] body_vel [2];
   logic signed [31:0] body_goal[2];
   logic               in_motion;
   motion_sample_type  expected_motion[$];

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647)
         return 64'sd2147483647;
      else if (v < -64'sd2147483648)
         return -64'sd2147483648;
      else
         return v;
   endfunction

   // unsigned coefficient times signed value, floored shift, clamped
   function automatic longint scale_sat(input logic [31:0] coef, input longint v,
                                        input int unsigned sh);
      longint prod;
      prod = longint'({32'd0, coef}) * v;
      return clamp32(prod >>> sh);
   endfunction

   function automatic longint unsigned mag_sq(input longint v);
      longint unsigned m;
      m = (v < 0) ? -v : v;
      return m * m;
   endfunction

   function automatic motion_sample_type advance_motion(input sdi_pkg::op_type op,
                                                        input logic signed [31:0] sx,
                                                        input logic signed [31:0] sy,
                                                        input logic signed [31:0] gx,
                                                        input logic signed [31:0] gy,
                                                        input logic [15:0] el);
      motion_sample_type r;
      longint d, fs, fd, f, acc;
      longint unsigned dsq, vsq, p2;
      int k;
      r.finished = 1'b0;
      dsq = 0;
      vsq = 0;
      if (op == sdi_pkg::OP_START) begin
         body_pos[0]  = sx;
         body_pos[1]  = sy;
         body_goal[0] = gx;
         body_goal[1] = gy;
         body_vel[0]  = '0;
         body_vel[1]  = '0;
         in_motion    = 1'b1;
      end else if (in_motion) begin
         if (el > params.max_duration_ms) begin
            in_motion  = 1'b0;
            r.finished = 1'b1;
         end else begin
            p2 = 64'(params.settle_precision) * 64'(params.settle_precision);
            for (k = 0; k < 2; k++) begin
               d   = clamp32(longint'(body_goal[k]) - longint'(body_pos[k]));
               fs  = scale_sat(params.stiffness, d, sdi_pkg::FracBits);
               fd  = scale_sat(params.damping, longint'(body_vel[k]), sdi_pkg::FracBits);
               f   = clamp32(fs - fd);
               acc = scale_sat(params.inverse_mass, f, sdi_pkg::FracBits);
               body_vel[k] = 32'(clamp32(longint'(body_vel[k]) +
                                 scale_sat({16'd0, params.time_step}, acc,
                                           sdi_pkg::DtFrac)));
               body_pos[k] = 32'(clamp32(longint'(body_pos[k]) +
                                 scale_sat({16'd0, params.time_step},
                                           longint'(body_vel[k]), sdi_pkg::DtFrac)));
            end
            for (k = 0; k < 2; k++) begin
               dsq += mag_sq(clamp32(longint'(body_goal[k]) - longint'(body_pos[k])));
               vsq += mag_sq(longint'(body_vel[k]));
            end
            if (dsq < p2 && vsq < p2) begin
               in_motion  = 1'b0;
               r.finished = 1'b1;
            end
         end
      end
      r.x      = body_pos[0];
      r.y      = body_pos[1];
      r.moving = in_motion;
      return r;
   endfunction

   task automatic flag_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
      if (want !== got) begin
         $display("%0t sdi_motion_checker: %s expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      motion_sample_type want;
      if (reset) begin
         params.stiffness        = DefStiffness;
         params.damping          = DefDamping;
         params.inverse_mass     = DefInverseMass;
         params.settle_precision = DefSettlePrec;
         params.max_duration_ms  = DefMaxDuration;
         params.time_step        = DefTimeStep;
         body_pos  = '{default: '0};
         body_vel  = '{default: '0};
         body_goal = '{default: '0};
         in_motion = 1'b0;
         expected_motion.delete();
         errors = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_motion.size() == 0) begin
               $display("%0t sdi_motion_checker: response %h %h %b %b with none expected",
                        $time, rsp.out_x, rsp.out_y, rsp.moving, rsp.finished);
               errors++;
            end else begin
               want = expected_motion.pop_front();
               flag_field("out_x", want.x, rsp.out_x);
               flag_field("out_y", want.y, rsp.out_y);
               flag_field("moving", 32'(want.moving), 32'(rsp.moving));
               flag_field("finished", 32'(want.finished), 32'(rsp.finished));
            end
         end
         if (csr.valid && csr.ready) begin
            case (sdi_pkg::csr_index_type'(csr.index))
               sdi_pkg::CSR_STIFFNESS:    params.stiffness        = csr.data;
               sdi_pkg::CSR_DAMPING:      params.damping          = csr.data;
               sdi_pkg::CSR_INVERSE_MASS: params.inverse_mass     = csr.data;
               sdi_pkg::CSR_SETTLE_PREC:  params.settle_precision = csr.data;
               sdi_pkg::CSR_MAX_DURATION: params.max_duration_ms  = csr.data[15:0];
               sdi_pkg::CSR_TIME_STEP:    params.time_step        = csr.data[15:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            expected_motion.push_back(advance_motion(sdi_pkg::op_type'(req.op), req.start_x,
                                                     req.start_y, req.goal_x,
                                                     req.goal_y, req.elapsed_ms));
      end
      pending = expected_motion.size();
   end

endmodule

### tb/sv/tb_spring_damper_integrator_2d.sv
// Testbench top for the spring-damper integrator: stimulus, back-pressure and verdict.
module tb_spring_damper_integrator_2d;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 250000;

   logic clock;
   logic reset;
   bit   quiet;        // when set, neither side idles
   int   cycle_count;
   int   errors;
   int   pending;

   sdi_req_if req_chan ();
   sdi_rsp_if rsp_chan ();
   sdi_csr_if csr_chan ();

   spring_damper_integrator_2d dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   sdi_motion_checker motion_checker (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .rsp     (rsp_chan),
      .csr     (csr_chan),
      .errors  (errors),
      .pending (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop should the block hang
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("tb_spring_damper_integrator_2d: done, errors");
         $finish;
      end
   end

   // Response side: random stall before each transaction, none while quiet.
   // Ready is only lowered when a stall is drawn, so it never toggles twice in a step.
   initial begin
      int stall;
      do @(negedge clock); while (reset);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 7);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         @(negedge clock);
      end
   end

   // One request transaction. Valid stays high afterwards unless the next one
   // draws a gap, so back-to-back transactions keep it asserted.
   task automatic send_request(input sdi_pkg::op_type op, input logic [31:0] sx,
                               input logic [31:0] sy, input logic [31:0] gx,
                               input logic [31:0] gy, input logic [15:0] el);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.op         <= op;
      req_chan.start_x    <= sx;
      req_chan.start_y    <= sy;
      req_chan.goal_x     <= gx;
      req_chan.goal_y     <= gy;
      req_chan.elapsed_ms <= el;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Sender holds off until every outstanding response is back.
   task automatic drain_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_reg(input sdi_pkg::csr_index_type idx, input logic [31:0] value);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 7);
      repeat (gap + 1) @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // Registers only change with the block idle and nothing in flight.
   task automatic set_motion_params(input logic [31:0] stiff, input logic [31:0] damp,
                                    input logic [31:0] imass, input logic [31:0] prec,
                                    input logic [31:0] maxdur, input logic [31:0] dt);
      drain_results();
      write_reg(sdi_pkg::CSR_STIFFNESS, stiff);
      write_reg(sdi_pkg::CSR_DAMPING, damp);
      write_reg(sdi_pkg::CSR_INVERSE_MASS, imass);
      write_reg(sdi_pkg::CSR_SETTLE_PREC, prec);
      write_reg(sdi_pkg::CSR_MAX_DURATION, maxdur);
      write_reg(sdi_pkg::CSR_TIME_STEP, dt);
   endtask

   // Mostly well-formed motions: a start near a random target, then a run of ticks
   // with rising elapsed time. The rest is noise: any op, any field content.
   // One sender pause until all responses are in falls somewhere mid-phase.
   task automatic run_motion_phase(input int quota);
      int sent, pause_at, ticks;
      bit paused;
      logic [31:0] gx, gy, sx, sy, off;
      logic [15:0] el;
      sent     = 0;
      paused   = 1'b0;
      pause_at = $urandom_range(quota / 4, 3 * quota / 4);
      while (sent < quota) begin
         if ($urandom_range(0, 9) < 8) begin
            gx  = $urandom;
            gx  = $signed(gx) >>> $urandom_range(0, 14);
            gy  = $urandom;
            gy  = $signed(gy) >>> $urandom_range(0, 14);
            off = $urandom;
            off = $signed(off) >>> $urandom_range(6, 28);
            sx  = gx + off;
            off = $urandom;
            off = $signed(off) >>> $urandom_range(6, 28);
            sy  = gy + off;
            send_request(sdi_pkg::OP_START, sx, sy, gx, gy, 16'($urandom));
            sent++;
            el    = '0;
            ticks = $urandom_range(1, 30);
            // the last motion of a phase is cut short at the quota
            if (ticks > quota - sent)
               ticks = quota - sent;
            repeat (ticks) begin
               // the odd jump in elapsed time forces early timeouts
               if ($urandom_range(0, 19) == 0)
                  el = 16'($urandom);
               else
                  el = el + 16'($urandom_range(0, 40));
               send_request(sdi_pkg::OP_TICK, $urandom, $urandom, $urandom, $urandom, el);
               sent++;
            end
         end else begin
            send_request(sdi_pkg::op_type'($urandom_range(0, 1)), $urandom, $urandom,
                         $urandom, $urandom, 16'($urandom));
            sent++;
         end
         if (!paused && sent >= pause_at) begin
            drain_results();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      reset               = 1'b1;
      quiet               = 1'b0;
      cycle_count         = 0;
      req_chan.valid      = 1'b0;
      req_chan.op         = sdi_pkg::OP_START;
      req_chan.start_x    = '0;
      req_chan.start_y    = '0;
      req_chan.goal_x     = '0;
      req_chan.goal_y     = '0;
      req_chan.elapsed_ms = '0;
      rsp_chan.ready      = 1'b0;
      csr_chan.valid      = 1'b0;
      csr_chan.index      = sdi_pkg::CSR_STIFFNESS;
      csr_chan.data       = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, reset register values.
      // ticks while idle hold the reset position
      send_request(sdi_pkg::OP_TICK, '0, '0, '0, '0, 16'd0);
      send_request(sdi_pkg::OP_TICK, '0, '0, '0, '0, 16'hFFFF);
      // extreme start and goal: differences saturate
      send_request(sdi_pkg::OP_START, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 16'd0);
      send_request(sdi_pkg::OP_TICK, '0, '0, '0, '0, 16'd0);
      send_request(sdi_pkg::OP_TICK, '0, '0, '0, '0, 16'd16);
      send_request(sdi_pkg::OP_TICK, '0, '0, '0, '0, 16'd32);
      // timeout, then a tick after the motion has stopped
      send_request(sdi_pkg::OP_TICK, '0, '0, '0, '0, 16'hFFFF);
      send_request(sdi_pkg::OP_TICK, '0, '0, '0, '0, 16'd48);
      // start already at the target: settles on the first tick
      send_request(sdi_pkg::OP_START, '0, '0, '0, '0, 16'd0);
      send_request(sdi_pkg::OP_TICK, '0, '0, '0, '0, 16'd0);
      // small offset, a few steps, then restart while still moving
      send_request(sdi_pkg::OP_START, 32'h0001_0000, 32'hFFFF_8000, '0, '0, 16'd0);
      send_request(sdi_pkg::OP_TICK, '0, '0, '0, '0, 16'd16);
      send_request(sdi_pkg::OP_TICK, '0, '0, '0, '0, 16'd32);
      send_request(sdi_pkg::OP_TICK, '0, '0, '0, '0, 16'd48);
      send_request(sdi_pkg::OP_START, 32'h0064_0000, 32'hFF9C_0000, 32'h0032_0000,
                   32'h0000_0001, 16'd0);
      send_request(sdi_pkg::OP_TICK, '0, '0, '0, '0, 16'd16);
      // at the limit still runs, one past it times out
      send_request(sdi_pkg::OP_TICK, '0, '0, '0, '0, 16'd1000);
      send_request(sdi_pkg::OP_TICK, '0, '0, '0, '0, 16'd1001);
      send_request(sdi_pkg::OP_START, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000,
                   32'h8000_0000, 16'd0);
      send_request(sdi_pkg::OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 16'd1);
      send_request(sdi_pkg::OP_TICK, '0, '0, '0, '0, 16'd2);

      // Explicit defaults, then all-zero and all-ones register extremes.
      set_motion_params(32'd6553600, 32'd655360, 32'd65536, 32'd655, 32'd1000, 32'd1049);
      run_motion_phase(60);
      set_motion_params('0, '0, '0, '0, '0, '0);
      run_motion_phase(50);
      set_motion_params('1, '1, '1, '1, 32'h0000_FFFF, 32'h0000_FFFF);
      run_motion_phase(50);

      // Physically plausible settings, with every third phase fully random.
      for (int i = 0; i < 9; i++) begin
         quiet = (i % 3 == 0);
         if (i % 3 == 2)
            set_motion_params($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         else
            set_motion_params($urandom_range(1 << 16, 400 << 16),
                              $urandom_range(0, 40 << 16),
                              $urandom_range(1 << 13, 4 << 16),
                              $urandom_range(64, 1 << 17),
                              $urandom_range(100, 65535),
                              $urandom_range(100, 4000));
         run_motion_phase(65);
      end

      drain_results();
      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("tb_spring_damper_integrator_2d: done, clean");
      else
         $display("tb_spring_damper_integrator_2d: done, errors");
      $finish;
   end

endmodule

### files.f
src/sdi_pkg.sv
src/sdi_if.sv
src/sdi_csr.sv
src/sdi_mul.sv
src/sdi_seq.sv
src/spring_damper_integrator_2d.sv
tb/sv/sdi_motion_checker.sv
tb/sv/tb_spring_damper_integrator_2d.sv
